// File: design/assert_macros.svh
// Assertion macros used by the list store top level.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked property, skipped while reset is asserted (active low).
`define OVLS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds during reset.
`define OVLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OVLS_ASSERT(lbl, clk, rstn, prop, msg)
`define OVLS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/ovls_pkg.sv
// Shared types and constants for the ordered value list store.
// Used by ovls_mem, ovls_out_reg and the top level; depends on nothing.
package ovls_pkg;

    // Default sizing of the store.
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed port widths.
    localparam int OP_W    = 3;
    localparam int IN_W    = 32;
    localparam int COUNT_W = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PREPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
    localparam logic [OP_W-1:0] OP_DROP     = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    // One result word.
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               rejected;
    } t_result;

endpackage

// File: design/ovls_mem.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on ovls_pkg for default sizes.
module ovls_mem
    import ovls_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [VALUE_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [VALUE_WIDTH-1:0] o_rdata
);

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ovls_out_reg.sv
// Output register for result words; frees the sequencer while a word waits.
// Depends on ovls_pkg for the result type.
module ovls_out_reg
    import ovls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load_valid,
    input  t_result i_load,
    output logic    o_load_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_load_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_result <= i_load;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/ordered_value_list_store.sv
// Top level of the ordered value list store: sequencer, entry memory and
// result register. Depends on ovls_pkg, ovls_mem, ovls_out_reg, assert_macros.svh.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_op, i_value
//   out     | output    | o_out_valid / i_out_stall  | o_found, o_count, o_rejected
//
// Append, clear, unused codes, refused insertions and drop or contains on an empty list
// finish without a walk. Prepend on a non-empty list, drop and contains walk the list
// one entry per cycle through the single memory read port; contains stops at a match.
// Reset (synchronous, active low) empties the list; the memory is not cleared.
// The input is stalled while a word is worked on; a finished result waits in the
// output register, so a stalled output holds back at most one word.
`include "assert_macros.svh"

module ordered_value_list_store
    import ovls_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [IN_W-1:0]    i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_rejected
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states. WALK streams entries through the memory read port:
    // upward shift for prepend, or a search for drop and contains, with a gap-closing shift for drop.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_FRONT = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                 r_state,    n_state;
    logic [VALUE_WIDTH-1:0] r_value,    n_value;
    logic [CW-1:0]          r_count,    n_count;
    logic [CW-1:0]          r_idx,      n_idx;
    logic                   r_pend,     n_pend;
    logic [AW-1:0]          r_tag,      n_tag;
    logic                   r_match,    n_match;
    logic                   r_found,    n_found;
    logic                   r_rejected, n_rejected;
    logic                   r_prepend,  n_prepend;
    logic                   r_contains, n_contains;

    logic                   in_accept;
    logic [VALUE_WIDTH-1:0] in_v;
    logic signed [63:0]     in_ext;
    logic                   full;
    logic [CW-1:0]          idx_dec;
    logic                   issue;
    logic                   hit;
    logic                   any_match;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic                   res_valid;
    logic                   out_ready;
    t_result                res;
    t_result                out_res;

    // The input word is accepted only by an idle sequencer.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // The 32-bit value is sign-extended, then kept at the stored width.
    assign in_ext = 64'(signed'(i_value));
    assign in_v   = in_ext[VALUE_WIDTH-1:0];

    assign full    = (r_count == CW'(DEPTH));
    assign idx_dec = r_idx - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_value    = r_value;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_tag      = r_tag;
        n_match    = r_match;
        n_found    = r_found;
        n_rejected = r_rejected;
        n_prepend  = r_prepend;
        n_contains = r_contains;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = r_value;
        mem_raddr  = '0;
        res_valid  = 1'b0;
        issue      = 1'b0;
        hit        = 1'b0;
        any_match  = r_match;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_value    = in_v;
                    n_found    = 1'b0;
                    n_rejected = 1'b0;
                    n_match    = 1'b0;
                    n_pend     = 1'b0;
                    n_prepend  = 1'b0;
                    n_contains = 1'b0;
                    n_state    = ST_DONE;
                    case (i_op)
                        OP_PREPEND: begin
                            if (full) begin
                                n_rejected = 1'b1;
                            end else if (r_count == '0) begin
                                n_state = ST_FRONT;
                            end else begin
                                n_prepend = 1'b1;
                                n_idx     = r_count;
                                n_state   = ST_WALK;
                            end
                        end
                        OP_APPEND: begin
                            if (full) begin
                                n_rejected = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = in_v;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_DROP, OP_CONTAINS: begin
                            n_contains = (i_op == OP_CONTAINS);
                            n_idx      = '0;
                            if (r_count != '0) begin
                                n_state = ST_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (r_prepend) begin
                    // Read from the back toward the front; each entry lands
                    // one place further back when its data returns.
                    issue     = (r_idx != '0);
                    mem_raddr = idx_dec[AW-1:0];
                    if (r_pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_tag + AW'(1);
                        mem_wdata = mem_rdata;
                    end
                    n_idx  = issue ? idx_dec : r_idx;
                    n_pend = issue;
                    n_tag  = mem_raddr;
                    if (!issue) begin
                        n_state = ST_FRONT;
                    end
                end else begin
                    // Search from the front. After the first match, a drop moves
                    // every later entry one place forward; a contains stops there.
                    hit       = r_pend && !r_match && (mem_rdata == r_value);
                    any_match = r_match || hit;
                    if (r_pend && r_match) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_tag - AW'(1);
                        mem_wdata = mem_rdata;
                    end
                    issue     = (r_idx != r_count) && !(r_contains && any_match);
                    mem_raddr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = issue;
                    n_tag     = mem_raddr;
                    n_match   = any_match;
                    if (!issue) begin
                        n_found = any_match;
                        if (any_match && !r_contains) begin
                            n_count = r_count - CW'(1);
                        end
                        n_state = ST_DONE;
                    end
                end
            end

            ST_FRONT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_value;
                n_count   = r_count + CW'(1);
                n_state   = ST_DONE;
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (out_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_match    <= 1'b0;
            r_found    <= 1'b0;
            r_rejected <= 1'b0;
            r_prepend  <= 1'b0;
            r_contains <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_match    <= n_match;
            r_found    <= n_found;
            r_rejected <= n_rejected;
            r_prepend  <= n_prepend;
            r_contains <= n_contains;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_idx   <= n_idx;
        r_tag   <= n_tag;
    end

    ovls_mem #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The reported count is the count after the operation, at port width.
    assign res.found    = r_found;
    assign res.count    = COUNT_W'(r_count);
    assign res.rejected = r_rejected;

    ovls_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (res_valid),
        .i_load       (res),
        .o_load_ready (out_ready),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_result     (out_res)
    );

    assign o_found    = out_res.found;
    assign o_count    = out_res.count;
    assign o_rejected = out_res.rejected;

    `OVLS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "entry count above depth")
    `OVLS_ASSERT(a_idle_write, i_clk, i_rst_n, (r_state == ST_IDLE) && mem_we |-> in_accept && (i_op == OP_APPEND), "memory written by an idle sequencer")
    `OVLS_ASSERT(a_reject_full, i_clk, i_rst_n, res_valid && r_rejected |-> r_count == CW'(DEPTH), "insertion refused below depth")
    `OVLS_ASSERT(a_walk_range, i_clk, i_rst_n, (r_state == ST_WALK) && !r_prepend |-> r_idx <= r_count, "search ran past the last entry")

endmodule

// File: tb/ordered_value_list_store_tb.sv
// Self-checking testbench for ordered_value_list_store: directed table, then random words.
// Depends on ovls_pkg and the ordered_value_list_store RTL only.
module ordered_value_list_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ovls_pkg::*;

    // The unused operation codes are all treated as no operation by the block.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_WORDS = 1250;
    localparam int POOL_SIZE    = 8;
    // The drain is longer than a prepend onto a list one short of full takes.
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    // Run length at which the watchdog ends the run, with room for all stalls and gaps.
    localparam int CYCLE_LIMIT  = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_op;
    logic [IN_W-1:0]    i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_found;
    logic [COUNT_W-1:0] o_count;
    logic               o_rejected;

    ordered_value_list_store i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_rejected  (o_rejected)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    // Shadow copy of the list. Position 0 is the front; only the first list_len
    // entries are meaningful, and only those are ever read.
    logic [IN_W-1:0] list_vals [LIST_DEPTH];
    int              list_len;

    // Results owed by the block, oldest first.
    t_result         expected_results [$];
    int              mismatch_count;
    int              cycle_count;

    // Sender pacing: words go out in bursts, mostly separated by idle gaps.
    int              burst_left;

    // One row of the directed table. When typed is set, the expected result is
    // written out in the row; otherwise it comes from the list shadow.
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [IN_W-1:0]    value;
        int                 reps;
        bit                 typed;
        logic               exp_found;
        logic [COUNT_W-1:0] exp_count;
        logic               exp_rejected;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 20;

    // Walks the empty-list corner cases, fills the list to the top with
    // duplicates, bounces insertions off the full list, and then clears it.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_CONTAINS,  32'h0000_0000,  1, 1'b1, 1'b0, 5'd0,  1'b0},
        '{OP_DROP,      32'h0000_0000,  1, 1'b1, 1'b0, 5'd0,  1'b0},
        '{OP_CLEAR,     32'h0000_0000,  1, 1'b1, 1'b0, 5'd0,  1'b0},
        '{OP_UNUSED_HI, 32'hFFFF_FFFF,  1, 1'b1, 1'b0, 5'd0,  1'b0},
        '{OP_APPEND,    32'h7FFF_FFFF,  1, 1'b1, 1'b0, 5'd1,  1'b0},
        '{OP_PREPEND,   32'h8000_0000,  1, 1'b1, 1'b0, 5'd2,  1'b0},
        '{OP_APPEND,    32'hFFFF_FFFF,  1, 1'b1, 1'b0, 5'd3,  1'b0},
        '{OP_APPEND,    32'h8000_0000,  1, 1'b1, 1'b0, 5'd4,  1'b0},
        '{OP_DROP,      32'h8000_0000,  1, 1'b1, 1'b1, 5'd3,  1'b0},
        '{OP_CONTAINS,  32'h8000_0000,  1, 1'b1, 1'b1, 5'd3,  1'b0},
        '{OP_DROP,      32'h0000_0001,  1, 1'b1, 1'b0, 5'd3,  1'b0},
        '{OP_UNUSED_LO, 32'h7FFF_FFFF,  1, 1'b1, 1'b0, 5'd3,  1'b0},
        '{OP_APPEND,    32'h0000_0000, 13, 1'b0, 1'b0, 5'd0,  1'b0},
        '{OP_PREPEND,   32'h0000_0001,  1, 1'b1, 1'b0, 5'd16, 1'b1},
        '{OP_APPEND,    32'h0000_0001,  1, 1'b1, 1'b0, 5'd16, 1'b1},
        '{OP_CONTAINS,  32'h0000_0000,  1, 1'b0, 1'b0, 5'd0,  1'b0},
        '{OP_DROP,      32'hFFFF_FFFF,  1, 1'b0, 1'b0, 5'd0,  1'b0},
        '{OP_PREPEND,   32'h5555_5555,  1, 1'b0, 1'b0, 5'd0,  1'b0},
        '{OP_CLEAR,     32'h5555_5555,  1, 1'b1, 1'b0, 5'd0,  1'b0},
        '{OP_DROP,      32'h5555_5555,  1, 1'b1, 1'b0, 5'd0,  1'b0}
    };

    // Applies one operation to the list shadow and returns the result word the
    // block must produce for it.
    function automatic t_result list_apply(input logic [OP_W-1:0] op,
                                           input logic [IN_W-1:0] value);
        t_result res;
        int      pos;
        res = '0;
        pos = list_len;
        if (op == OP_DROP || op == OP_CONTAINS) begin
            for (int i = list_len - 1; i >= 0; i--) begin
                if (list_vals[i] == value) begin
                    pos = i;
                end
            end
        end
        case (op)
            OP_PREPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.rejected = 1'b1;
                end else begin
                    for (int i = list_len; i > 0; i--) begin
                        list_vals[i] = list_vals[i-1];
                    end
                    list_vals[0] = value;
                    list_len++;
                end
            end
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.rejected = 1'b1;
                end else begin
                    list_vals[list_len] = value;
                    list_len++;
                end
            end
            OP_DROP: begin
                // Only the first match from the front goes; later entries close up.
                if (pos < list_len) begin
                    res.found = 1'b1;
                    for (int i = pos; i + 1 < list_len; i++) begin
                        list_vals[i] = list_vals[i+1];
                    end
                    list_len--;
                end
            end
            OP_CONTAINS: begin
                res.found = (pos < list_len);
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    // Inserts the idle gap, if any, that ends a burst, then starts a new burst.
    // Called in the time step of a rising edge, before the next word is offered.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Offers one word and holds it until the block takes it. The expectation is
    // recorded at the edge of acceptance, so the shadow list moves in step with
    // the block. Valid stays high from one word to the next when there is no gap.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [IN_W-1:0] value,
                             input bit typed, input t_result typed_res);
        t_result predicted;
        pace_sender();
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predicted = list_apply(op, value);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    // Receiver: stalls the output on a random pattern that is redrawn after each random run,
    // including stretches with no stall at all.
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} t_stall_mode;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;

    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_run  = $urandom_range(10, 60);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_WAVE:  i_out_stall <= stall_run[2];
            default:     i_out_stall <= 1'b0;
        endcase
    end

    // Result checker: every accepted result word is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word with nothing expected: found %0b count %0d rejected %0b",
                         $time, o_found, o_count, o_rejected);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_found !== want.found || o_count !== want.count ||
                    o_rejected !== want.rejected) begin
                    $display("%0t: expected found %0b count %0d rejected %0b, got found %0b count %0d rejected %0b",
                             $time, want.found, want.count, want.rejected,
                             o_found, o_count, o_rejected);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [IN_W-1:0] value_pool [POOL_SIZE];
        logic [OP_W-1:0] op;
        logic [IN_W-1:0] value;
        t_result         typed_res;
        bit              grow_mode;
        int              r;
        int              ins_w;
        int              drop_w;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= OP_CLEAR;
        i_value        <= '0;
        i_out_stall    <= 1'b0;
        list_len       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;

        // A small pool of values makes matches, duplicates and drops frequent.
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            typed_res.found    = directed_rows[row].exp_found;
            typed_res.count    = directed_rows[row].exp_count;
            typed_res.rejected = directed_rows[row].exp_rejected;
            for (int k = 0; k < directed_rows[row].reps; k++) begin
                send_word(directed_rows[row].op, directed_rows[row].value,
                          directed_rows[row].typed, typed_res);
            end
        end

        // Random words. The list swings between growing toward full and
        // shrinking toward empty, so both ends and every depth between are hit.
        grow_mode = 1'b1;
        typed_res = '0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (grow_mode && list_len == LIST_DEPTH && $urandom_range(0, 4) == 0) begin
                grow_mode = 1'b0;
            end else if (!grow_mode && list_len == 0) begin
                grow_mode = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                grow_mode = !grow_mode;
            end

            ins_w  = grow_mode ? 28 : 12;
            drop_w = grow_mode ? 16 : 45;
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                op = OP_PREPEND;
            end else if (r < 2 * ins_w) begin
                op = OP_APPEND;
            end else if (r < 2 * ins_w + drop_w) begin
                op = OP_DROP;
            end else if (r < 94) begin
                op = OP_CONTAINS;
            end else if (r < 96) begin
                op = OP_CLEAR;
            end else begin
                op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end

            // Mostly values already in the list or in the pool, some fully random.
            r = $urandom_range(0, 99);
            if (r < 40 && list_len > 0) begin
                value = list_vals[$urandom_range(0, list_len - 1)];
            end else if (r < 75) begin
                value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                value = $urandom;
            end

            send_word(op, value, 1'b0, typed_res);
        end
        i_in_valid <= 1'b0;

        // Wait for every owed result, then give a stray late word time to show.
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/ovls_pkg.sv
design/ovls_mem.sv
design/ovls_out_reg.sv
design/ordered_value_list_store.sv
tb/ordered_value_list_store_tb.sv
